/* rtl/ans_pkg.sv */
// ----------------------------------------------------------------------------
// ans_pkg
// Shared widths, codes and reset values for the ant next-node selector.
// ----------------------------------------------------------------------------
package ans_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int MAX_NODES_DEF   = 256;
  localparam int WEIGHT_BITS_DEF = 32;

  // Fixed field widths of the channels.
  localparam int OP_W           = 2;
  localparam int NODE_FIELD_W   = 8;
  localparam int WEIGHT_FIELD_W = 32;
  localparam int RAND_W         = 16;
  localparam int STATUS_W       = 2;
  localparam int COUNT_W        = 9;
  localparam int THR_W          = 17;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 17;

  // Operation codes of an input transaction.
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_START = 2'd1;
  localparam logic [OP_W-1:0] OP_MOVE  = 2'd2;

  // Status codes of a result transaction.
  localparam logic [STATUS_W-1:0] ST_MOVED   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_LOADED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_STARTED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NONE    = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPLOIT_THR = 2'd1;

  // Register reset values and limits.
  localparam logic [COUNT_W-1:0] NODE_COUNT_RST  = 9'd256;
  localparam logic [THR_W-1:0]   EXPLOIT_THR_RST = 17'd58982;
  localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;

endpackage

/* rtl/ans_if.sv */
// ----------------------------------------------------------------------------
// ans_if
// Valid/ready channels of the ant next-node selector: input items, results
// and configuration writes.
// ----------------------------------------------------------------------------

// Input item channel.
interface ans_in_if import ans_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           op;
  logic [NODE_FIELD_W-1:0]   row;
  logic [NODE_FIELD_W-1:0]   col;
  logic [WEIGHT_FIELD_W-1:0] weight;
  logic [NODE_FIELD_W-1:0]   start_node;
  logic [RAND_W-1:0]         random_pick;
  logic [RAND_W-1:0]         random_roulette;

  modport source (output valid, op, row, col, weight, start_node, random_pick,
                  random_roulette, input ready);
  modport sink (input valid, op, row, col, weight, start_node, random_pick,
                random_roulette, output ready);
endinterface

// Result channel.
interface ans_out_if import ans_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [NODE_FIELD_W-1:0] next_node;
  logic [STATUS_W-1:0]     status;
  logic [COUNT_W-1:0]      visited_count;

  modport source (output valid, next_node, status, visited_count, input ready);
  modport sink (input valid, next_node, status, visited_count, output ready);
endinterface

// Configuration write channel.
interface ans_cfg_if import ans_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/ans_target_mul.sv */
// ----------------------------------------------------------------------------
// ans_target_mul
// Sequential multiplier for the roulette target: floor(total * frac / 65536),
// one 16-bit slice of the total per cycle, highest slice first.
// ----------------------------------------------------------------------------
module ans_target_mul import ans_pkg::*; #(
  parameter int SUM_W = WEIGHT_BITS_DEF + 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SUM_W-1:0]  total,
  input  logic [RAND_W-1:0] frac,
  output logic              done,
  output logic [SUM_W-1:0]  target
);

  localparam int NCHUNK = (SUM_W + RAND_W - 1) / RAND_W;
  localparam int TOT_W  = NCHUNK * RAND_W;
  localparam int ACC_W  = TOT_W + RAND_W;
  localparam int KW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [KW-1:0]     k_r, k_nxt;
  logic [TOT_W-1:0]  tot_r, tot_nxt;
  logic [RAND_W-1:0] frac_r, frac_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [RAND_W-1:0] chunk;
  logic [2*RAND_W-1:0] prod;

  // Current slice times the fraction.
  assign chunk = tot_r[{k_r, 4'b0000} +: RAND_W];
  assign prod  = chunk * frac_r;

  // Shift-and-add over the slices.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    k_nxt    = k_r;
    tot_nxt  = tot_r;
    frac_nxt = frac_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      k_nxt    = KW'(NCHUNK - 1);
      tot_nxt  = TOT_W'(total);
      frac_nxt = frac;
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt = {acc_r[ACC_W-RAND_W-1:0], {RAND_W{1'b0}}} + ACC_W'(prod);
      if (k_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        k_nxt = k_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    k_r    <= k_nxt;
    tot_r  <= tot_nxt;
    frac_r <= frac_nxt;
    acc_r  <= acc_nxt;
  end

  assign done   = done_r;
  assign target = acc_r[RAND_W +: SUM_W];

endmodule

/* rtl/ant_next_node_select.sv */
// ----------------------------------------------------------------------------
// ant_next_node_select
// Next-node choice of one ant in tour construction: greedy pick of the best
// unvisited node or a weighted roulette, over a loaded weight table.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake      Contents
//  cfg_ch   in   valid/ready    register index, write data (always ready)
//  in_ch    in   valid/ready    op, row, col, weight, start_node, randoms
//  out_ch   out  valid/ready    next_node, status, visited_count
//
// A load passes straight to the result state; a start makes one pass over the
// visited memory to set up the tour. An exploiting move scans once, an
// exploring move scans twice with the roulette target multiplier between the
// scans; the scans go over the weight row and visited memory, one entry per
// cycle through their single read port. One item is in work at a time; a new
// item is taken while the last result still waits in the output register.
// Reset is synchronous and needs no clearing pass; weights are undefined
// until loaded. A stalled result holds the block in its result state only.
// ----------------------------------------------------------------------------
module ant_next_node_select import ans_pkg::*; #(
  parameter int MAX_NODES   = MAX_NODES_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ans_cfg_if.sink    cfg_ch,
  ans_in_if.sink     in_ch,
  ans_out_if.source  out_ch
);

  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam int CUR_W  = (NODE_W > NODE_FIELD_W) ? NODE_W : NODE_FIELD_W;
  localparam int SUM_W  = WEIGHT_BITS + NODE_W;
  localparam int DEPTH  = MAX_NODES * MAX_NODES;
  localparam int ADDR_W = $clog2(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_SWEEP, S_SCAN1, S_MUL, S_SCAN2, S_FINISH, S_RESULT
  } state_t;

  // Memories: weight table and visited flags.
  logic [WEIGHT_BITS-1:0] wmem [DEPTH];
  logic                   vmem [MAX_NODES];

  // Control and datapath registers.
  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   pvld_r, pvld_nxt;
  logic [NODE_W-1:0]      pidx_r, pidx_nxt;
  logic [WEIGHT_BITS-1:0] wrd_r;
  logic                   vrd_r;
  logic [WEIGHT_BITS-1:0] best_r, best_nxt;
  logic [NODE_W-1:0]      chosen_r, chosen_nxt;
  logic [NODE_W-1:0]      first_r, first_nxt;
  logic                   any_r, any_nxt;
  logic                   hit_r, hit_nxt;
  logic [SUM_W-1:0]       total_r, total_nxt;
  logic [SUM_W-1:0]       run_r, run_nxt;
  logic                   explore_r, explore_nxt;
  logic [RAND_W-1:0]      roul_r, roul_nxt;
  logic [CNT_W-1:0]       tour_n_r, tour_n_nxt;
  logic                   tour_active_r, tour_active_nxt;
  logic [CUR_W-1:0]       cur_r, cur_nxt;
  logic [COUNT_W-1:0]     visited_r, visited_nxt;
  logic [COUNT_W-1:0]     node_count_r, node_count_nxt;
  logic [THR_W-1:0]       thr_r, thr_nxt;
  logic [NODE_FIELD_W-1:0] res_node_r, res_node_nxt;
  logic [STATUS_W-1:0]    res_status_r, res_status_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [NODE_FIELD_W-1:0] out_node_r, out_node_nxt;
  logic [STATUS_W-1:0]    out_status_r, out_status_nxt;
  logic [COUNT_W-1:0]     out_count_r, out_count_nxt;

  // Memory ports.
  logic                   wmem_we;
  logic [ADDR_W-1:0]      wmem_wa, wmem_ra;
  logic [WEIGHT_BITS-1:0] wmem_wd;
  logic                   vmem_we;
  logic [NODE_W-1:0]      vmem_wa;
  logic                   vmem_wd;

  // Helpers.
  logic                   in_fire, out_fire, cfg_fire;
  logic                   cur_ok, row_ok, scan_issue, scan_end, unv, sweep_last;
  logic [NODE_W-1:0]      scan_idx, cur_idx, sel;
  logic [WEIGHT_BITS-1:0] w_cur;
  logic [SUM_W-1:0]       run_sum;
  logic                   mul_start, mul_done;
  logic [SUM_W-1:0]       mul_target;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign cfg_fire = cfg_ch.valid && cfg_ch.ready;

  // Scan bookkeeping: reads go out at cnt_r, data comes back in the next cycle.
  assign scan_idx   = cnt_r[NODE_W-1:0];
  assign scan_issue = (32'(cnt_r) < MAX_NODES);
  assign scan_end   = !scan_issue && !pvld_r;
  assign sweep_last = (32'(cnt_r) == MAX_NODES - 1);
  assign cur_ok     = (32'(cur_r) < MAX_NODES);
  assign cur_idx    = cur_r[NODE_W-1:0];
  assign row_ok     = (32'(in_ch.row) < MAX_NODES) && (32'(in_ch.col) < MAX_NODES);
  assign w_cur      = cur_ok ? wrd_r : '0;
  assign unv        = tour_active_r && (32'(pidx_r) < 32'(tour_n_r)) && !vrd_r;
  assign run_sum    = run_r + SUM_W'(w_cur);
  assign sel        = (!explore_r || hit_r) ? chosen_r : first_r;
  assign mul_start  = (state_r == S_SCAN1) && scan_end && explore_r;

  // Weight memory addresses.
  assign wmem_ra = ADDR_W'(32'(cur_idx) * MAX_NODES + 32'(scan_idx));
  assign wmem_wa = ADDR_W'(32'(in_ch.row) * MAX_NODES + 32'(in_ch.col));
  assign wmem_wd = WEIGHT_BITS'(in_ch.weight);
  assign wmem_we = in_fire && (in_ch.op == OP_LOAD) && row_ok;

  // Visited memory write: set-up sweep or marking the chosen node.
  always_comb begin
    vmem_we = 1'b0;
    vmem_wa = scan_idx;
    vmem_wd = 1'b0;
    if (state_r == S_SWEEP) begin
      vmem_we = 1'b1;
      vmem_wd = (32'(cnt_r) == 32'(cur_r));
    end else if ((state_r == S_FINISH) && any_r) begin
      vmem_we = 1'b1;
      vmem_wa = sel;
      vmem_wd = 1'b1;
    end
  end

  // Roulette target multiplier.
  ans_target_mul #(
    .SUM_W (SUM_W)
  ) u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .total  (total_r),
    .frac   (roul_r),
    .done   (mul_done),
    .target (mul_target)
  );

  // Next-state logic.
  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    pvld_nxt        = 1'b0;
    pidx_nxt        = pidx_r;
    best_nxt        = best_r;
    chosen_nxt      = chosen_r;
    first_nxt       = first_r;
    any_nxt         = any_r;
    hit_nxt         = hit_r;
    total_nxt       = total_r;
    run_nxt         = run_r;
    explore_nxt     = explore_r;
    roul_nxt        = roul_r;
    tour_n_nxt      = tour_n_r;
    tour_active_nxt = tour_active_r;
    cur_nxt         = cur_r;
    visited_nxt     = visited_r;
    node_count_nxt  = node_count_r;
    thr_nxt         = thr_r;
    res_node_nxt    = res_node_r;
    res_status_nxt  = res_status_r;
    out_valid_nxt   = out_valid_r && !out_fire;
    out_node_nxt    = out_node_r;
    out_status_nxt  = out_status_r;
    out_count_nxt   = out_count_r;

    // Configuration writes.
    if (cfg_fire) begin
      unique case (cfg_ch.index)
        REG_NODE_COUNT:  node_count_nxt = cfg_ch.data[COUNT_W-1:0];
        REG_EXPLOIT_THR: thr_nxt = cfg_ch.data[THR_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_ch.op)
            OP_LOAD: begin
              res_node_nxt   = '0;
              res_status_nxt = ST_LOADED;
              state_nxt      = S_RESULT;
            end
            OP_START: begin
              tour_n_nxt      = (32'(node_count_r) > MAX_NODES) ?
                                CNT_W'(MAX_NODES) : CNT_W'(node_count_r);
              tour_active_nxt = 1'b1;
              cur_nxt         = CUR_W'(in_ch.start_node);
              visited_nxt     = COUNT_W'(1);
              res_node_nxt    = in_ch.start_node;
              res_status_nxt  = ST_STARTED;
              cnt_nxt         = '0;
              state_nxt       = S_SWEEP;
            end
            OP_MOVE: begin
              explore_nxt = !(THR_W'(in_ch.random_pick) < thr_r);
              roul_nxt    = in_ch.random_roulette;
              best_nxt    = '0;
              chosen_nxt  = '0;
              first_nxt   = '0;
              any_nxt     = 1'b0;
              hit_nxt     = 1'b0;
              total_nxt   = '0;
              run_nxt     = '0;
              cnt_nxt     = '0;
              state_nxt   = S_SCAN1;
            end
            default: ;
          endcase
        end
      end

      // Write the visited flag of every node, only the start node set.
      S_SWEEP: begin
        cnt_nxt = cnt_r + 1'b1;
        if (sweep_last) begin
          state_nxt = S_RESULT;
        end
      end

      // Greedy maximum, or the sum of unvisited weights for the roulette.
      S_SCAN1: begin
        if (scan_issue) begin
          cnt_nxt  = cnt_r + 1'b1;
          pvld_nxt = 1'b1;
          pidx_nxt = scan_idx;
        end
        if (pvld_r && unv) begin
          if (explore_r) begin
            total_nxt = total_r + SUM_W'(w_cur);
          end else begin
            any_nxt = 1'b1;
            if (!any_r || (w_cur > best_r)) begin
              best_nxt   = w_cur;
              chosen_nxt = pidx_r;
            end
          end
        end
        if (scan_end) begin
          cnt_nxt   = '0;
          state_nxt = explore_r ? S_MUL : S_FINISH;
        end
      end

      S_MUL: begin
        if (mul_done) begin
          state_nxt = S_SCAN2;
        end
      end

      // Roulette: first unvisited node whose running sum passes the target.
      S_SCAN2: begin
        if (scan_issue) begin
          cnt_nxt  = cnt_r + 1'b1;
          pvld_nxt = 1'b1;
          pidx_nxt = scan_idx;
        end
        if (pvld_r && unv && !hit_r) begin
          any_nxt = 1'b1;
          run_nxt = run_sum;
          if (!any_r) begin
            first_nxt = pidx_r;
          end
          if (run_sum > mul_target) begin
            chosen_nxt = pidx_r;
            hit_nxt    = 1'b1;
          end
        end
        if (scan_end) begin
          state_nxt = S_FINISH;
        end
      end

      // Commit the move, or report that no node is left.
      S_FINISH: begin
        if (any_r) begin
          cur_nxt        = CUR_W'(sel);
          visited_nxt    = (visited_r != COUNT_MAX) ? visited_r + 1'b1 : visited_r;
          res_node_nxt   = NODE_FIELD_W'(sel);
          res_status_nxt = ST_MOVED;
        end else begin
          res_node_nxt   = cur_r[NODE_FIELD_W-1:0];
          res_status_nxt = ST_NONE;
        end
        state_nxt = S_RESULT;
      end

      // Hand the result to the output register once it is free.
      S_RESULT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_node_nxt   = res_node_r;
          out_status_nxt = res_status_r;
          out_count_nxt  = visited_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      pvld_r        <= 1'b0;
      tour_active_r <= 1'b0;
      cur_r         <= '0;
      visited_r     <= '0;
      node_count_r  <= NODE_COUNT_RST;
      thr_r         <= EXPLOIT_THR_RST;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      pvld_r        <= pvld_nxt;
      tour_active_r <= tour_active_nxt;
      cur_r         <= cur_nxt;
      visited_r     <= visited_nxt;
      node_count_r  <= node_count_nxt;
      thr_r         <= thr_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    cnt_r        <= cnt_nxt;
    pidx_r       <= pidx_nxt;
    best_r       <= best_nxt;
    chosen_r     <= chosen_nxt;
    first_r      <= first_nxt;
    any_r        <= any_nxt;
    hit_r        <= hit_nxt;
    total_r      <= total_nxt;
    run_r        <= run_nxt;
    explore_r    <= explore_nxt;
    roul_r       <= roul_nxt;
    tour_n_r     <= tour_n_nxt;
    res_node_r   <= res_node_nxt;
    res_status_r <= res_status_nxt;
    out_node_r   <= out_node_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  // Weight table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wmem_we) begin
      wmem[wmem_wa] <= wmem_wd;
    end
    wrd_r <= wmem[wmem_ra];
  end

  // Visited flags: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (vmem_we) begin
      vmem[vmem_wa] <= vmem_wd;
    end
    vrd_r <= vmem[scan_idx];
  end

  // Port drive.
  assign cfg_ch.ready         = 1'b1;
  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.next_node     = out_node_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.visited_count = out_count_r;

  // The multiplier reports completion only while the block waits for it.
  a_mul_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == S_MUL))
    else $error("roulette target finished outside its wait state");

  // Scan read data is only pending inside a scan pass.
  a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    pvld_r |-> ((state_r == S_SCAN1) || (state_r == S_SCAN2)))
    else $error("scan read data pending outside a scan pass");

  // The visited count changes only on a start or on a committed move.
  a_visited_update: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (visited_r != $past(visited_r))) |->
      ($past(state_r == S_FINISH) || $past(in_fire)))
    else $error("visited count changed outside a start or a move");

  // A result appears only after the result state.
  a_out_from_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESULT))
    else $error("result raised outside the result state");

endmodule
